// ===== hw/rtl/cse_pkg.sv =====
`default_nettype none

package cse_pkg;

    localparam int MAX_COEFS = 64;
    localparam int COEF_AW   = $clog2(MAX_COEFS);
    localparam int COUNT_W   = 7;
    localparam int W_W       = 110;   // working significand: 53 bits + 57 bits below

    localparam logic [63:0] FP_ZERO     = 64'h0000_0000_0000_0000;
    localparam logic [63:0] FP_TWO      = 64'h4000_0000_0000_0000;
    localparam logic [63:0] FP_HALF     = 64'h3FE0_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

    localparam logic ADDR_COEF_COUNT = 1'b0;   // paddr[2]

    // req_type codes carried in tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef enum logic [1:0] {
        FP_MUL,
        FP_ADD,
        FP_SUB
    } fp_op_t;

    typedef struct packed {
        logic   start;
        fp_op_t op;
    } fp_req_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_ALIGN,
        F_NORM,
        F_DENORM,
        F_ROUND
    } fpu_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TWO,
        ST_HALF,
        ST_MUL,
        ST_ADD,
        ST_SUB,
        ST_RD0,
        ST_C0,
        ST_OUT
    } seq_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/chebyshev_series_evaluator_unit.sv =====
`default_nettype none

// Chebyshev series evaluator: a load beat (tuser = 0) writes one IEEE double coefficient
// into a 64-entry store. An evaluate beat (tuser = 1) returns sum a_k*T_k(x) over
// coef_count coefficients, using the Clenshaw recurrence with every multiply, add and
// subtract rounded to nearest even on its own. All arithmetic runs through one shared
// double-precision unit: a multiply of normal operands forms four 27x27 partial
// products, then normalizes and rounds; an add or subtract aligns, normalizes and
// rounds. Subnormal operands or deep cancellation lengthen an operation, and zero,
// infinite or NaN operands finish early. An evaluation with coef_count of two or more
// issues 2 + 3*coef_count operations; counts of zero and one issue none. The
// input is not ready while an evaluation runs. Coefficients must be loaded before they
// are used; coef_count (register 0) above 64 acts as 64.

module chebyshev_series_evaluator_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata,   // coef_index[5:0], coef_value[69:6], point_x[133:70]
    input  wire logic [0:0]   s_tuser,   // req_type
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // series_value
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import cse_pkg::*;

    seq_state_t         state_reg, state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COEF_AW-1:0] k_reg, k_next;
    logic [63:0]        x_reg, x_next;
    logic [63:0]        t_reg, t_next;
    logic [63:0]        ht_reg, ht_next;
    logic [63:0]        near_reg, near_next;
    logic [63:0]        far_reg, far_next;
    logic [63:0]        tmp_reg, tmp_next;
    logic [63:0]        final_reg, final_next;
    logic [63:0]        out_data_reg, out_data_next;
    logic               out_valid_reg, out_valid_next;
    logic               go_reg, go_next;

    logic               in_acc, is_eval, out_load;
    logic [COUNT_W-1:0] n_sat;
    logic [COEF_AW-1:0] coef_index;
    logic [63:0]        coef_value, point_x, coef_rd;

    fp_req_t            fp_req;
    logic [63:0]        fp_a, fp_b, fp_y;
    logic               fp_done;

    assign coef_index = s_tdata[5:0];
    assign coef_value = s_tdata[69:6];
    assign point_x    = s_tdata[133:70];
    assign is_eval    = (s_tuser[0] == REQ_EVAL);
    assign in_acc     = s_tvalid & s_tready;
    assign n_sat      = (count_reg > COUNT_W'(MAX_COEFS)) ? COUNT_W'(MAX_COEFS) : count_reg;
    assign out_load   = (state_reg == ST_OUT) & (~out_valid_reg | m_tready);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (psel & penable & pwrite & pready & (paddr[2] == ADDR_COEF_COUNT))
        begin
            count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_COEF_COUNT) ? {{(32-COUNT_W){1'b0}}, count_reg} : 32'd0;

    cse_ram #(
        .WIDTH (64),
        .DEPTH (MAX_COEFS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (in_acc & ~is_eval),
        .waddr (coef_index),
        .wdata (coef_value),
        .raddr (k_reg),
        .rdata (coef_rd)
    );

    cse_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fp_req),
        .a     (fp_a),
        .b     (fp_b),
        .done  (fp_done),
        .y     (fp_y)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc & is_eval)
                begin
                    if (n_sat == '0)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (n_sat == COUNT_W'(1))
                    begin
                        state_next = ST_RD0;
                    end
                    else
                    begin
                        state_next = ST_TWO;
                    end
                end
            end
            ST_TWO:  state_next = fp_done ? ST_HALF : ST_TWO;
            ST_HALF: state_next = fp_done ? ST_MUL : ST_HALF;
            ST_MUL:  state_next = fp_done ? ST_ADD : ST_MUL;
            ST_ADD:  state_next = fp_done ? ST_SUB : ST_ADD;
            ST_SUB:
            begin
                if (fp_done)
                begin
                    state_next = (k_reg == '0) ? ST_OUT : ST_MUL;
                end
            end
            ST_RD0:  state_next = ST_C0;
            ST_C0:   state_next = ST_OUT;
            ST_OUT:  state_next = out_load ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        k_next        = k_reg;
        x_next        = x_reg;
        t_next        = t_reg;
        ht_next       = ht_reg;
        near_next     = near_reg;
        far_next      = far_reg;
        tmp_next      = tmp_reg;
        final_next    = final_reg;
        out_data_next = out_data_reg;
        fp_req.op     = FP_MUL;
        fp_a          = FP_ZERO;
        fp_b          = FP_ZERO;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc & is_eval)
                begin
                    k_next     = COEF_AW'(n_sat - COUNT_W'(1));
                    x_next     = point_x;
                    near_next  = FP_ZERO;
                    far_next   = FP_ZERO;
                    final_next = FP_ZERO;
                end
            end
            ST_TWO:
            begin
                fp_req.op = FP_MUL;
                fp_a      = x_reg;
                fp_b      = FP_TWO;
                if (fp_done)
                begin
                    t_next = fp_y;
                end
            end
            ST_HALF:
            begin
                fp_req.op = FP_MUL;
                fp_a      = FP_HALF;
                fp_b      = t_reg;
                if (fp_done)
                begin
                    ht_next = fp_y;
                end
            end
            ST_MUL:
            begin
                // the last step (a_0) uses x instead of 2x
                fp_req.op = FP_MUL;
                fp_a      = (k_reg == '0) ? ht_reg : t_reg;
                fp_b      = near_reg;
                if (fp_done)
                begin
                    tmp_next = fp_y;
                end
            end
            ST_ADD:
            begin
                fp_req.op = FP_ADD;
                fp_a      = coef_rd;
                fp_b      = tmp_reg;
                if (fp_done)
                begin
                    tmp_next = fp_y;
                end
            end
            ST_SUB:
            begin
                fp_req.op = FP_SUB;
                fp_a      = tmp_reg;
                fp_b      = far_reg;
                if (fp_done)
                begin
                    if (k_reg == '0)
                    begin
                        final_next = fp_y;
                    end
                    else
                    begin
                        far_next  = near_reg;
                        near_next = fp_y;
                        k_next    = k_reg - COEF_AW'(1);
                    end
                end
            end
            ST_C0:
            begin
                final_next = coef_rd;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_data_next = final_reg;
                end
            end
            default:
            begin
            end
        endcase

        go_next = (state_next != state_reg) &&
                  ((state_next == ST_TWO) || (state_next == ST_HALF) ||
                   (state_next == ST_MUL) || (state_next == ST_ADD) ||
                   (state_next == ST_SUB));
        fp_req.start   = go_reg;
        out_valid_next = (out_valid_reg & ~m_tready) | out_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            go_reg        <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            go_reg        <= go_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        t_reg        <= t_next;
        ht_reg       <= ht_next;
        near_reg     <= near_next;
        far_reg      <= far_next;
        tmp_reg      <= tmp_next;
        final_reg    <= final_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cse_ram.sv =====
`default_nettype none

module cse_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cse_fpu.sv =====
`default_nettype none

module cse_fpu (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cse_pkg::fp_req_t req,
    input  wire logic [63:0]      a,
    input  wire logic [63:0]      b,
    output logic                  done,
    output logic [63:0]           y
);
    import cse_pkg::*;

    fpu_state_t        state_reg, state_next;
    logic              done_reg, done_next;
    logic [63:0]       y_reg, y_next;
    logic              sgn_reg, sgn_next;
    logic              sub_reg, sub_next;
    logic signed [12:0] exp_reg, exp_next;
    logic [52:0]       ma_reg, ma_next;
    logic [52:0]       mb_reg, mb_next;
    logic [11:0]       d_reg, d_next;
    logic [W_W-1:0]    w_reg, w_next;
    logic [53:0]       pp_reg, pp_next;
    logic [2:0]        cnt_reg, cnt_next;

    // operand decode
    logic              a_nan, a_inf, a_zero, b_nan, b_inf, b_zero, sbe, a_big;
    logic [52:0]       a_m, b_m;
    logic signed [11:0] a_e, b_e;
    logic signed [12:0] e_diff, den_s;

    // shared right shifter with sticky folded into bit 0
    logic [W_W-1:0]    sh_in, sh_out, sh_mask;
    logic [6:0]        sh_amt;
    logic              sh_stk;

    logic [W_W-1:0]    wa, wsum, pp_term;
    logic [6:0]        pp_sh;
    logic [26:0]       mx, my;

    // rounding
    logic [52:0]       rmant, m53;
    logic [53:0]       m54;
    logic              rinc;
    logic signed [12:0] exp_r, biased;

    always_comb
    begin
        a_nan  = (&a[62:52]) & (|a[51:0]);
        a_inf  = (&a[62:52]) & ~(|a[51:0]);
        a_zero = ~(|a[62:0]);
        b_nan  = (&b[62:52]) & (|b[51:0]);
        b_inf  = (&b[62:52]) & ~(|b[51:0]);
        b_zero = ~(|b[62:0]);
        a_m    = {|a[62:52], a[51:0]};
        b_m    = {|b[62:52], b[51:0]};
        a_e    = $signed({1'b0, ((|a[62:52]) ? a[62:52] : 11'd1)}) - 12'sd1023;
        b_e    = $signed({1'b0, ((|b[62:52]) ? b[62:52] : 11'd1)}) - 12'sd1023;
        sbe    = b[63] ^ (req.op == FP_SUB);
        a_big  = (a[62:0] >= b[62:0]);
        e_diff = a_big ? ($signed({a_e[11], a_e}) - $signed({b_e[11], b_e}))
                       : ($signed({b_e[11], b_e}) - $signed({a_e[11], a_e}));
        den_s  = -13'sd1022 - exp_reg;
    end

    always_comb
    begin
        if (state_reg == F_ALIGN)
        begin
            sh_in  = {1'b0, mb_reg, 56'b0};
            sh_amt = (|d_reg[11:7]) ? 7'd127 : d_reg[6:0];
        end
        else
        begin
            sh_in  = w_reg;
            sh_amt = (|den_s[12:7]) ? 7'd127 : den_s[6:0];
        end
        sh_mask = ~({W_W{1'b1}} << sh_amt);
        sh_stk  = |(sh_in & sh_mask);
        sh_out  = (sh_in >> sh_amt) | {{(W_W-1){1'b0}}, sh_stk};
    end

    always_comb
    begin
        wa   = {1'b0, ma_reg, 56'b0};
        wsum = sub_reg ? (wa - sh_out) : (wa + sh_out);
        mx   = cnt_reg[1] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
        my   = cnt_reg[0] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];
        // weight of the partial product captured in the previous cycle
        unique case (cnt_reg)
            3'd1:    pp_sh = 7'd4;
            3'd2,
            3'd3:    pp_sh = 7'd31;
            default: pp_sh = 7'd58;
        endcase
        pp_term = {{(W_W-54){1'b0}}, pp_reg} << pp_sh;
    end

    always_comb
    begin
        rmant  = w_reg[109:57];
        rinc   = w_reg[56] & ((|w_reg[55:0]) | w_reg[57]);
        m54    = {1'b0, rmant} + {53'b0, rinc};
        m53    = m54[53] ? m54[53:1] : m54[52:0];
        exp_r  = m54[53] ? (exp_reg + 13'sd1) : exp_reg;
        biased = exp_r + 13'sd1023;
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        y_next     = y_reg;
        sgn_next   = sgn_reg;
        sub_next   = sub_reg;
        exp_next   = exp_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        d_next     = d_reg;
        w_next     = w_reg;
        pp_next    = pp_reg;
        cnt_next   = cnt_reg;

        unique case (state_reg)
            F_IDLE:
            begin
                if (req.start)
                begin
                    if (req.op == FP_MUL)
                    begin
                        if (a_nan)
                        begin
                            y_next = a | 64'h0008_0000_0000_0000;
                            done_next = 1'b1;
                        end
                        else if (b_nan)
                        begin
                            y_next = b | 64'h0008_0000_0000_0000;
                            done_next = 1'b1;
                        end
                        else if ((a_inf & b_zero) | (a_zero & b_inf))
                        begin
                            y_next = DEFAULT_NAN;
                            done_next = 1'b1;
                        end
                        else if (a_inf | b_inf)
                        begin
                            y_next = {a[63] ^ b[63], 11'h7FF, 52'b0};
                            done_next = 1'b1;
                        end
                        else if (a_zero | b_zero)
                        begin
                            y_next = {a[63] ^ b[63], 63'b0};
                            done_next = 1'b1;
                        end
                        else
                        begin
                            sgn_next   = a[63] ^ b[63];
                            exp_next   = $signed({a_e[11], a_e}) + $signed({b_e[11], b_e})
                                         + 13'sd1;
                            ma_next    = a_m;
                            mb_next    = b_m;
                            w_next     = '0;
                            cnt_next   = 3'd0;
                            state_next = F_MUL;
                        end
                    end
                    else
                    begin
                        if (a_nan)
                        begin
                            y_next = a | 64'h0008_0000_0000_0000;
                            done_next = 1'b1;
                        end
                        else if (b_nan)
                        begin
                            y_next = b | 64'h0008_0000_0000_0000;
                            done_next = 1'b1;
                        end
                        else if (a_inf & b_inf & (a[63] != sbe))
                        begin
                            y_next = DEFAULT_NAN;
                            done_next = 1'b1;
                        end
                        else if (a_inf)
                        begin
                            y_next = a;
                            done_next = 1'b1;
                        end
                        else if (b_inf)
                        begin
                            y_next = {sbe, b[62:0]};
                            done_next = 1'b1;
                        end
                        else if (a_zero & b_zero)
                        begin
                            y_next = {a[63] & sbe, 63'b0};
                            done_next = 1'b1;
                        end
                        else if (a_zero)
                        begin
                            y_next = {sbe, b[62:0]};
                            done_next = 1'b1;
                        end
                        else if (b_zero)
                        begin
                            y_next = a;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            sub_next   = a[63] ^ sbe;
                            sgn_next   = a_big ? a[63] : sbe;
                            ma_next    = a_big ? a_m : b_m;
                            mb_next    = a_big ? b_m : a_m;
                            exp_next   = a_big ? ($signed({a_e[11], a_e}) + 13'sd1)
                                               : ($signed({b_e[11], b_e}) + 13'sd1);
                            d_next     = e_diff[11:0];
                            state_next = F_ALIGN;
                        end
                    end
                end
            end

            F_MUL:
            begin
                if (cnt_reg != 3'd4)
                begin
                    pp_next = mx * my;
                end
                if (cnt_reg != 3'd0)
                begin
                    w_next = w_reg + pp_term;
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    state_next = F_NORM;
                end
            end

            F_ALIGN:
            begin
                if (wsum == '0)
                begin
                    y_next     = FP_ZERO;
                    done_next  = 1'b1;
                    state_next = F_IDLE;
                end
                else
                begin
                    w_next     = wsum;
                    state_next = F_NORM;
                end
            end

            F_NORM:
            begin
                if (w_reg[109])
                begin
                    state_next = (exp_reg < -13'sd1022) ? F_DENORM : F_ROUND;
                end
                else if (w_reg[109:102] == 8'd0)
                begin
                    w_next   = w_reg << 8;
                    exp_next = exp_reg - 13'sd8;
                end
                else
                begin
                    w_next   = w_reg << 1;
                    exp_next = exp_reg - 13'sd1;
                end
            end

            F_DENORM:
            begin
                w_next     = sh_out;
                exp_next   = -13'sd1022;
                state_next = F_ROUND;
            end

            F_ROUND:
            begin
                if (biased >= 13'sd2047)
                begin
                    y_next = {sgn_reg, 11'h7FF, 52'b0};
                end
                else
                begin
                    y_next = {sgn_reg, (m53[52] ? biased[10:0] : 11'd0), m53[51:0]};
                end
                done_next  = 1'b1;
                state_next = F_IDLE;
            end

            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg   <= y_next;
        sgn_reg <= sgn_next;
        sub_reg <= sub_next;
        exp_reg <= exp_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        d_reg   <= d_next;
        w_reg   <= w_next;
        pp_reg  <= pp_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cse_checker.sv =====
`default_nettype none

module cse_assert (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [0:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [63:0]  m_tdata,
    input wire logic         pready
);

    // a result held back by the sink stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // an evaluate beat occupies the block
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
        else $error("input ready right after an evaluate beat");

    // a coefficient load never produces a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser[0] && !m_tvalid |=> !m_tvalid)
        else $error("result appeared after a load beat");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind chebyshev_series_evaluator_unit cse_assert u_cse_assert (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

`default_nettype wire

// ===== test/cse_checker.sv =====
`timescale 1ns / 1ps

module cse_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [135:0] s_tdata,   // coef_index[5:0], coef_value[69:6], point_x[133:70]
    input  wire logic [0:0]   s_tuser,   // req_type
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [63:0]  m_tdata,   // series_value
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    input  wire logic         pready,
    output int                fail_count,
    output int                pending
);
    import cse_pkg::*;

    logic [63:0]        coef_mem [MAX_COEFS];
    logic [COUNT_W-1:0] terms;
    logic [63:0]        series_q [$];

    assign pending = series_q.size();

    function automatic bit is_nan(logic [63:0] b);
        return (&b[62:52]) && (|b[51:0]);
    endfunction

    function automatic real coef(int k);
        return $bitstoreal(coef_mem[k]);
    endfunction

    // Clenshaw recurrence, pairs of steps from the top, every operation rounded alone
    function automatic logic [63:0] clenshaw_sum(logic [63:0] xb);
        int  n;
        int  k;
        real t, b1, b2, keep, p, s;
        n = (terms > MAX_COEFS) ? MAX_COEFS : int'(terms);
        if (n == 0)
            return FP_ZERO;
        if (n == 1)
            return coef_mem[0];
        t  = $bitstoreal(xb) * 2.0;
        b1 = 0.0;
        b2 = 0.0;
        for (k = n - 1; k > 1; k -= 2)
        begin
            p  = t * b1;
            s  = coef(k) + p;
            b2 = s - b2;
            p  = t * b2;
            s  = coef(k - 1) + p;
            b1 = s - b1;
        end
        if ((n - 1) % 2 == 1)
        begin
            keep = b1;
            p    = t * b1;
            s    = coef(1) + p;
            b1   = s - b2;
            b2   = keep;
        end
        p = 0.5 * t;
        p = p * b1;
        s = coef(0) + p;
        return $realtobits(s - b2);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terms = '0;
            series_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == ADDR_COEF_COUNT)
                terms = pwdata[COUNT_W-1:0];
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == REQ_LOAD)
                    coef_mem[s_tdata[5:0]] = s_tdata[69:6];
                else
                    series_q.insert(series_q.size(), clenshaw_sum(s_tdata[133:70]));
            end
            if (m_tvalid && m_tready)
            begin
                if (series_q.size() == 0)
                    report_mismatch("unexpected beat", m_tdata, '0);
                else
                begin
                    logic [63:0] want;
                    want = series_q.pop_front();
                    // NaN payloads are not pinned down, only the class
                    if (is_nan(want) ? !is_nan(m_tdata) : (m_tdata !== want))
                        report_mismatch("series_value", m_tdata, want);
                end
            end
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import cse_pkg::*;

    localparam int   CYCLE_LIMIT = 20_000_000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;  // coef_index[5:0], coef_value[69:6], point_x[133:70]
    logic [0:0]   s_tuser = '0;  // req_type
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;       // series_value
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int fail_count;
    int pending;
    int cycles = 0;
    int items = 0;
    bit quiet = 1'b0;
    bit want_hold = 1'b0;
    int hold_left = 0;
    int gap_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    chebyshev_series_evaluator_unit i_dut (.*);

    cse_checker i_checker (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (want_hold)
        begin
            want_hold = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (quiet)
            m_tready <= 1'b1;
        else if (gap_left > 0)
        begin
            gap_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            gap_left = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    function automatic logic [63:0] pick_real(bit wide);
        real r;
        if (wide && $urandom_range(0, 4) == 0)
            return {$urandom, $urandom};
        r = (real'($urandom_range(0, 4000)) - 2000.0) / 1024.0;
        if ($urandom_range(0, 7) == 0)
            r = r * 1.0e10;
        return $realtobits(r);
    endfunction

    task automatic send_beat(logic req, logic [5:0] idx, logic [63:0] val, logic [63:0] x);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, x, val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items++;
    endtask

    task automatic load_coef(logic [5:0] idx, logic [63:0] val);
        send_beat(REQ_LOAD, idx, val, {$urandom, $urandom});
    endtask

    task automatic eval_at(logic [63:0] x);
        send_beat(REQ_EVAL, 6'($urandom), {$urandom, $urandom}, x);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_terms(logic [6:0] n);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ADDR_COEF_COUNT, 2'b00};
        pwdata  <= {$urandom_range(0, 1) ? 25'h1ffffff : 25'($urandom), n};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        logic [63:0] specials [8];
        int          n;
        int          burst;
        specials = '{FP_ZERO, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                     64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
                     64'h0000_0000_0000_0001, 64'h3FF0_0000_0000_0000,
                     64'hBFE8_0000_0000_0000};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small counts, edge values, special points
        load_coef(6'd0, 64'h4009_21FB_5444_2D18);
        load_coef(6'd1, 64'hC000_0000_0000_0000);
        load_coef(6'd2, 64'h0000_0000_0000_0001);
        load_coef(6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
        load_coef(6'd3, 64'h3FF8_0000_0000_0000);
        drain();
        for (int c = 0; c < 4; c++)
        begin
            set_terms(7'(c));
            for (int j = 0; j < 4; j++)
                eval_at(specials[(c * 2 + j) % 8]);
            drain();
        end

        // random: fill the store first so every later count reads written entries
        for (int k = 0; k < MAX_COEFS; k++)
            load_coef(6'(k), pick_real(1'b1));
        drain();

        for (int ph = 0; items < 1470; ph++)
        begin
            if (items > 1350)
                quiet = 1'b1;
            if (ph % 9 == 4)
                n = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
            else
                n = $urandom_range(0, 10);
            set_terms(7'(n));
            burst = (n > 10) ? 10 : 40;
            if (ph == 3)
                want_hold = 1'b1;
            for (int j = 0; j < burst; j++)
            begin
                if ($urandom_range(0, 1) == 0)
                    load_coef(6'($urandom), pick_real(1'b1));
                else if ($urandom_range(0, 15) == 0)
                    eval_at(specials[$urandom_range(0, 7)]);
                else
                    eval_at($urandom_range(0, 5) == 0 ? {$urandom, $urandom}
                            : $realtobits((real'($urandom_range(0, 3000)) - 1500.0) / 1000.0));
                if (ph == 6 && j == 20)
                    drain();
            end
            drain();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cse_pkg.sv
hw/rtl/cse_ram.sv
hw/rtl/cse_fpu.sv
hw/rtl/chebyshev_series_evaluator_unit.sv
hw/rtl/cse_checker.sv
test/cse_checker.sv
test/testbench.sv
